/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Needs nothing else; define NO_ASSERTIONS to compile all checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check with the module's own clk_i and rst_ni.
`define BBA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("allocator assertion failed");
// Check with an explicit clock and active-low reset.
`define BBA_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator assertion failed");
`else
`define BBA_ASSERT(name, prop)
`define BBA_ASSERT_CLK(name, clk, rst_n, prop)
`endif
`endif

/* hw/rtl/bba_pkg.sv */
// Shared types, constants and helper functions of the block allocator.
// No dependencies; every other RTL file of the block imports it.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned SlotW        = 6;            // block index width
  localparam int unsigned SlotN        = 1 << SlotW;   // largest store size
  localparam int unsigned NumBlocksDef = 64;
  localparam int unsigned ReqW         = 16;
  localparam int unsigned SizeW        = 17;
  localparam int unsigned LogW         = 5;            // log2 of a side, 0 to 16
  localparam int unsigned RunLogW      = 3;
  localparam int unsigned RunW         = 7;
  localparam int unsigned BlkSideW     = 13;
  localparam int unsigned BlkLogW      = 4;
  localparam int unsigned MemSideW     = 17;
  localparam int unsigned AddrW        = 3;
  localparam int unsigned DataW        = 32;
  localparam int unsigned RegSelBit    = 2;

  localparam logic [BlkSideW-1:0] BlockSideRst  = 13'd32;
  localparam logic [MemSideW-1:0] MemorySideRst = 17'd4096;

  typedef enum logic [1:0] {
    ActAllocExact = 2'd0,
    ActAllocAny   = 2'd1,
    ActFree       = 2'd2,
    ActClear      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoSpace = 2'd1,
    StTooBig  = 2'd2,
    StMissing = 2'd3
  } status_e;

  typedef enum logic {
    RegBlockSide  = 1'b0,
    RegMemorySide = 1'b1
  } reg_e;

  // Command from the sequencer to the store.
  typedef struct packed {
    logic               scan;      // capture the free-run vector for run_log
    logic               alloc;     // take the first captured run, if any
    logic               free_run;  // release start/len
    logic               wipe;      // release everything
    logic               rd_en;     // read the entry at rd_slot
    logic [SlotW-1:0]   rd_slot;
    logic [RunLogW-1:0] run_log;
    logic [SlotW-1:0]   start;
    logic [RunW-1:0]    len;
  } store_cmd_t;

  // Answer from the store.
  typedef struct packed {
    logic               found;
    logic [SlotW-1:0]   start;
    logic               ent_valid;
    logic [RunLogW-1:0] ent_log;
  } store_rsp_t;

  // Largest power of two not above v, as a log; zero gives zero.
  function automatic logic [BlkLogW-1:0] floor_log2_blk(input logic [BlkSideW-1:0] v);
    logic [BlkLogW-1:0] r;
    r = '0;
    for (int i = 1; i < BlkSideW; i++) begin
      if (v[i]) r = BlkLogW'(i);
    end
    return r;
  endfunction

  // Log of v rounded up to a power of two; zero and one give zero.
  function automatic logic [LogW-1:0] ceil_log2_req(input logic [ReqW-1:0] v);
    logic [ReqW-1:0] m;
    logic [LogW-1:0] r;
    m = v - ReqW'(1);
    r = '0;
    if (v > ReqW'(1)) begin
      for (int i = 0; i < ReqW; i++) begin
        if (m[i]) r = LogW'(i + 1);
      end
    end
    return r;
  endfunction

  // Bits start to start+len-1 set.
  function automatic logic [SlotN-1:0] range_mask(input logic [RunW-1:0] start,
                                                   input logic [RunW-1:0] len);
    logic [SlotN-1:0] m;
    logic [RunW:0]    stop;
    stop = {1'b0, start} + {1'b0, len};
    for (int j = 0; j < SlotN; j++) begin
      m[j] = ((RunW + 1)'(j) >= {1'b0, start}) && ((RunW + 1)'(j) < stop);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/bba_regs.sv */
// Configuration registers (block side, memory side) behind the APB-style port.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bba_pkg::AddrW-1:0]            paddr,
  input  logic [bba_pkg::DataW-1:0]            pwdata,
  output logic [bba_pkg::DataW-1:0]            prdata,
  output logic                                 pready,
  output logic [bba_pkg::BlkSideW-1:0]         block_side_o,
  output logic [bba_pkg::MemSideW-1:0]         memory_side_o
);
  import bba_pkg::*;

  logic [BlkSideW-1:0] block_side_q, block_side_d;
  logic [MemSideW-1:0] memory_side_q, memory_side_d;
  logic                wr;
  reg_e                sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[RegSelBit]);

  always_comb begin
    block_side_d  = block_side_q;
    memory_side_d = memory_side_q;
    prdata        = '0;
    unique case (sel)
      RegBlockSide: begin
        prdata = DataW'(block_side_q);
        if (wr) block_side_d = pwdata[BlkSideW-1:0];
      end
      RegMemorySide: begin
        prdata = DataW'(memory_side_q);
        if (wr) memory_side_d = pwdata[MemSideW-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_side_q  <= BlockSideRst;
      memory_side_q <= MemorySideRst;
    end else begin
      block_side_q  <= block_side_d;
      memory_side_q <= memory_side_d;
    end
  end

  assign block_side_o  = block_side_q;
  assign memory_side_o = memory_side_q;

endmodule

/* hw/rtl/bba_store.sv */
// Allocation store: usage map, entry valid bits, run-size memory and free-run search.
// Depends on bba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_store #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NumBlocksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bba_pkg::store_cmd_t cmd_i,
  output bba_pkg::store_rsp_t rsp_o
);
  import bba_pkg::*;

  localparam int unsigned IdxW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [NUM_BLOCKS-1:0] usage_q, usage_d;
  logic [NUM_BLOCKS-1:0] valid_q, valid_d;
  logic [RunLogW-1:0]    log_mem [NUM_BLOCKS];
  logic [RunLogW-1:0]    rd_log_q;
  logic                  rd_valid_q;
  logic [SlotN-1:0]      cand_q;
  logic [SlotN-1:0]      free_w;
  logic [SlotN-1:0]      lvl [SlotW+1];
  logic                  found;
  logic [SlotW-1:0]      grp;
  logic [SlotW-1:0]      start;
  logic                  alloc_hit;
  logic [IdxW-1:0]       wr_idx, fr_idx, rd_idx;
  logic [SlotN-1:0]      set_mask, clr_mask;

  // Level k marks the aligned groups of 2**k blocks that are wholly free.
  // Positions past the store count as used, so partial groups never match.
  always_comb begin
    free_w                 = '0;
    free_w[NUM_BLOCKS-1:0] = ~usage_q;
    lvl[0]                 = free_w;
    for (int k = 1; k <= SlotW; k++) begin
      lvl[k] = '0;
      for (int i = 0; i < (SlotN >> k); i++) begin
        lvl[k][i] = lvl[k-1][2*i] & lvl[k-1][2*i+1];
      end
    end
  end

  // Lowest free group in the captured vector.
  always_comb begin
    found = |cand_q;
    grp   = '0;
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (cand_q[i]) grp = SlotW'(i);
    end
  end

  assign start     = grp << cmd_i.run_log;
  assign alloc_hit = cmd_i.alloc && found;
  assign wr_idx    = start[IdxW-1:0];
  assign fr_idx    = cmd_i.start[IdxW-1:0];
  assign rd_idx    = cmd_i.rd_slot[IdxW-1:0];
  assign set_mask  = range_mask(RunW'(start), RunW'(1) << cmd_i.run_log);
  assign clr_mask  = range_mask(RunW'(cmd_i.start), cmd_i.len);

  always_comb begin
    usage_d = usage_q;
    valid_d = valid_q;
    if (cmd_i.wipe) begin
      usage_d = '0;
      valid_d = '0;
    end else if (alloc_hit) begin
      usage_d         = usage_q | set_mask[NUM_BLOCKS-1:0];
      valid_d[wr_idx] = 1'b1;
    end else if (cmd_i.free_run) begin
      usage_d         = usage_q & ~clr_mask[NUM_BLOCKS-1:0];
      valid_d[fr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usage_q <= '0;
      valid_q <= '0;
    end else begin
      usage_q <= usage_d;
      valid_q <= valid_d;
    end
  end

  // Run-size memory with a registered read; the entry's valid bit is read with it.
  always_ff @(posedge clk_i) begin
    if (alloc_hit) log_mem[wr_idx] <= cmd_i.run_log;
    if (cmd_i.rd_en) begin
      rd_log_q   <= log_mem[rd_idx];
      rd_valid_q <= valid_q[rd_idx];
    end
    if (cmd_i.scan) cand_q <= lvl[cmd_i.run_log];
  end

  assign rsp_o.found     = found;
  assign rsp_o.start     = start;
  assign rsp_o.ent_valid = rd_valid_q;
  assign rsp_o.ent_log   = rd_log_q;

  `BBA_ASSERT(a_alloc_marks, alloc_hit |=> (usage_q[$past(wr_idx)] && valid_q[$past(wr_idx)]))
  `BBA_ASSERT(a_wipe_clears, cmd_i.wipe |=> ((usage_q == '0) && (valid_q == '0)))
  `BBA_ASSERT(a_free_drops, (cmd_i.free_run && !cmd_i.wipe) |=> !valid_q[$past(fr_idx)])

endmodule

/* hw/rtl/bba_ctrl.sv */
// Request sequencer: size rounding, allocation tries with halving, free and clear,
// and the output register. Depends on bba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bba_ctrl #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [bba_pkg::ReqW-1:0]      req_width_i,
  input  logic [bba_pkg::ReqW-1:0]      req_height_i,
  input  logic [bba_pkg::SlotW-1:0]     slot_to_free_i,
  input  logic [bba_pkg::BlkSideW-1:0]  block_side_i,
  input  logic [bba_pkg::MemSideW-1:0]  memory_side_i,
  output bba_pkg::store_cmd_t           cmd_o,
  input  bba_pkg::store_rsp_t           rsp_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [bba_pkg::SlotW-1:0]     slot_index_o,
  output logic [bba_pkg::RunW-1:0]      run_blocks_o,
  output logic [bba_pkg::SizeW-1:0]     granted_width_o,
  output logic [bba_pkg::SizeW-1:0]     granted_height_o
);
  import bba_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] STry   = 3'd1;
  localparam logic [2:0] SPick  = 3'd2;
  localparam logic [2:0] SFree  = 3'd3;
  localparam logic [2:0] SClear = 3'd4;
  localparam logic [2:0] SEmit  = 3'd5;

  logic [2:0]         state_q, state_d;
  action_e            act_q, act_d;
  logic [LogW-1:0]    lw_q, lw_d, lh_q, lh_d;
  logic [RunLogW-1:0] lrun_q, lrun_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic               all_big_q, all_big_d;

  status_e            res_status_q, res_status_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;
  logic [RunW-1:0]    res_run_q, res_run_d;
  logic [SizeW-1:0]   res_gw_q, res_gw_d, res_gh_q, res_gh_d;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [RunW-1:0]    out_run_q;
  logic [SizeW-1:0]   out_gw_q, out_gh_q;

  logic               accept, load;
  action_e            act_in;
  logic [LogW-1:0]    bl5, lw_in, lh_in, lbig, lrun_full;
  logic [SizeW-1:0]   gw, gh;
  logic               too_big, run_over, last_try, try_fail, try_big;
  logic [RunW:0]      run8;
  logic [RunW-1:0]    rem, run_free;

  assign act_in = action_e'(action_i);
  assign accept = in_valid_i && (state_q == SIdle);
  assign bl5    = LogW'(floor_log2_blk(block_side_i));

  // Any-size requests start no smaller than one block.
  always_comb begin
    lw_in = ceil_log2_req(req_width_i);
    lh_in = ceil_log2_req(req_height_i);
    if (act_in == ActAllocAny) begin
      if (lw_in < bl5) lw_in = bl5;
      if (lh_in < bl5) lh_in = bl5;
    end
  end

  assign gw        = SizeW'(1) << lw_q;
  assign gh        = SizeW'(1) << lh_q;
  assign too_big   = (gw >= memory_side_i) || (gh >= memory_side_i);
  assign lbig      = (lw_q > lh_q) ? lw_q : lh_q;
  assign lrun_full = (lbig > bl5) ? (lbig - bl5) : '0;
  assign run_over  = ((SizeW + 1)'(1) << lrun_full) > (SizeW + 1)'(NUM_BLOCKS);
  assign last_try  = (act_q == ActAllocExact) || (lw_q == bl5) || (lh_q == bl5);
  assign try_fail  = ((state_q == STry) && (too_big || run_over)) ||
                     ((state_q == SPick) && !rsp_i.found);
  assign try_big   = (state_q == STry) && too_big;

  // Free: recorded run length, trimmed to the end of the store.
  assign run8     = (RunW + 1)'(1) << rsp_i.ent_log;
  assign rem      = RunW'(NUM_BLOCKS) - RunW'(slot_q);
  assign run_free = (run8 > {1'b0, rem}) ? rem : run8[RunW-1:0];

  assign load = (state_q == SEmit) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    lw_d         = lw_q;
    lh_d         = lh_q;
    lrun_d       = lrun_q;
    slot_d       = slot_q;
    all_big_d    = all_big_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_run_d    = res_run_q;
    res_gw_d     = res_gw_q;
    res_gh_d     = res_gh_q;
    cmd_o        = '0;
    cmd_o.run_log = lrun_q;
    cmd_o.start   = slot_q;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          act_d         = act_in;
          lw_d          = lw_in;
          lh_d          = lh_in;
          slot_d        = slot_to_free_i;
          all_big_d     = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = slot_to_free_i;
          unique case (act_in) inside
            ActAllocExact, ActAllocAny: state_d = STry;
            ActFree:                    state_d = SFree;
            ActClear:                   state_d = SClear;
            default:                    state_d = SIdle;
          endcase
        end
      end
      STry: begin
        lrun_d = lrun_full[RunLogW-1:0];
        if (!too_big && !run_over) begin
          cmd_o.scan    = 1'b1;
          cmd_o.run_log = lrun_full[RunLogW-1:0];
          state_d       = SPick;
        end
      end
      SPick: begin
        cmd_o.alloc = 1'b1;
        if (rsp_i.found) begin
          res_status_d = StOk;
          res_slot_d   = rsp_i.start;
          res_run_d    = RunW'(1) << lrun_q;
          res_gw_d     = gw;
          res_gh_d     = gh;
          state_d      = SEmit;
        end
      end
      SFree: begin
        res_gw_d = '0;
        res_gh_d = '0;
        if ((RunW'(slot_q) >= RunW'(NUM_BLOCKS)) || !rsp_i.ent_valid) begin
          res_status_d = StMissing;
          res_slot_d   = '0;
          res_run_d    = '0;
        end else begin
          cmd_o.free_run = 1'b1;
          cmd_o.len      = run_free;
          res_status_d   = StOk;
          res_slot_d     = slot_q;
          res_run_d      = run_free;
        end
        state_d = SEmit;
      end
      SClear: begin
        cmd_o.wipe   = 1'b1;
        res_status_d = StOk;
        res_slot_d   = '0;
        res_run_d    = '0;
        res_gw_d     = '0;
        res_gh_d     = '0;
        state_d      = SEmit;
      end
      SEmit: begin
        if (load) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase

    // A failed try either ends the request or retries with both sides halved.
    if (try_fail) begin
      if (last_try) begin
        res_status_d = (all_big_q && try_big) ? StTooBig : StNoSpace;
        res_slot_d   = '0;
        res_run_d    = '0;
        res_gw_d     = '0;
        res_gh_d     = '0;
        state_d      = SEmit;
      end else begin
        all_big_d = all_big_q && try_big;
        lw_d      = lw_q - LogW'(1);
        lh_d      = lh_q - LogW'(1);
        state_d   = STry;
      end
    end
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    lw_q         <= lw_d;
    lh_q         <= lh_d;
    lrun_q       <= lrun_d;
    slot_q       <= slot_d;
    all_big_q    <= all_big_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_run_q    <= res_run_d;
    res_gw_q     <= res_gw_d;
    res_gh_q     <= res_gh_d;
    if (load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_run_q    <= res_run_q;
      out_gw_q     <= res_gw_q;
      out_gh_q     <= res_gh_q;
    end
  end

  assign in_stall_o       = (state_q != SIdle);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign slot_index_o     = out_slot_q;
  assign run_blocks_o     = out_run_q;
  assign granted_width_o  = out_gw_q;
  assign granted_height_o = out_gh_q;

  `BBA_ASSERT(a_pick_after_try, (state_q == SPick) |-> ($past(state_q) == STry))
  `BBA_ASSERT(a_grant_aligned, (out_valid_q && (out_status_q == StOk) && (out_run_q != '0)) |-> ((out_slot_q & (out_run_q[SlotW-1:0] - SlotW'(1))) == '0))
  `BBA_ASSERT(a_grant_pow2, (out_valid_q && (out_gw_q != '0)) |-> ($onehot(out_gw_q) && $onehot(out_gh_q)))

endmodule

/* hw/rtl/aligned_block_bitmap_allocator_top.sv */
// Top level of the aligned block bitmap allocator.
// Depends on bba_pkg, bba_regs, bba_store and bba_ctrl.
`timescale 1ns / 1ps

// Usage:
// Requests enter on in_valid_i/in_stall_o; one transfer carries action_i, req_width_i,
// req_height_i and slot_to_free_i. Every request gives exactly one result transfer on
// out_valid_o/out_stall_i with status_o, slot_index_o, run_blocks_o and the granted
// power-of-two sides. One request is worked on at a time; in_stall_o is high while it is.
// A clear or a free passes through its own state and then the emit state; a free uses
// the registered read of the run-size memory issued when the request is taken. An exact
// allocation passes through the try and pick states, or goes from try straight to emit
// when it is too big or needs more blocks than the store holds. An any-size allocation
// repeats try, and pick for each size that is scanned, halving both sides after each
// failed size. A scan captures the free-run vector of the usage map and then takes the
// lowest free aligned run. The next request is taken in the cycle after a result is
// loaded. The result sits in an output register, so a new request is taken while a
// result waits; a stalled receiver holds the result and then, once the sequencer
// finishes the next request, the input side as well. Reset marks every block free,
// drops all allocations and loads the default block side (32) and memory side (4096).
// The configuration port must be written only when idle; the block does not enforce it.
module aligned_block_bitmap_allocator_top #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NumBlocksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [bba_pkg::ReqW-1:0]      req_width_i,
  input  logic [bba_pkg::ReqW-1:0]      req_height_i,
  input  logic [bba_pkg::SlotW-1:0]     slot_to_free_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [bba_pkg::SlotW-1:0]     slot_index_o,
  output logic [bba_pkg::RunW-1:0]      run_blocks_o,
  output logic [bba_pkg::SizeW-1:0]     granted_width_o,
  output logic [bba_pkg::SizeW-1:0]     granted_height_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::AddrW-1:0]     paddr,
  input  logic [bba_pkg::DataW-1:0]     pwdata,
  output logic [bba_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import bba_pkg::*;

  logic [BlkSideW-1:0] block_side;
  logic [MemSideW-1:0] memory_side;
  store_cmd_t          cmd;
  store_rsp_t          rsp;

  bba_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .block_side_o  (block_side),
    .memory_side_o (memory_side)
  );

  bba_store #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  bba_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .req_width_i      (req_width_i),
    .req_height_i     (req_height_i),
    .slot_to_free_i   (slot_to_free_i),
    .block_side_i     (block_side),
    .memory_side_i    (memory_side),
    .cmd_o            (cmd),
    .rsp_i            (rsp),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .run_blocks_o     (run_blocks_o),
    .granted_width_o  (granted_width_o),
    .granted_height_o (granted_height_o)
  );

endmodule

/* tb/aligned_block_bitmap_allocator_top_tb.sv */
// Self-checking testbench for aligned_block_bitmap_allocator_top: predicts every result
// from its own allocator model and compares each result transfer field by field.
// Depends on bba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module aligned_block_bitmap_allocator_top_tb;
  import bba_pkg::*;

  localparam int unsigned BlockCount = NumBlocksDef;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 244;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned SettleCycles = 40;

  typedef struct packed {
    status_e         status;
    logic [SlotW-1:0] slot;
    logic [RunW-1:0]  run;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } alloc_result_t;

  // Allocator model plus the queue of results it has promised.
  class alloc_scoreboard;
    int unsigned     blk_side_q;
    int unsigned     mem_side_q;
    logic [63:0]     used_map;
    bit              alloc_start[BlockCount];
    bit [2:0]        alloc_log[BlockCount];
    alloc_result_t   expected_q[$];
    int unsigned     err_count;

    function new();
      blk_side_q = BlockSideRst;
      mem_side_q = MemorySideRst;
      used_map   = '0;
      err_count  = 0;
      foreach (alloc_start[i]) begin
        alloc_start[i] = 1'b0;
        alloc_log[i]   = '0;
      end
    endfunction

    function void set_config(reg_e idx, int unsigned value);
      if (idx == RegBlockSide) blk_side_q = value & 32'h1FFF;
      else mem_side_q = value & 32'h1FFFF;
    endfunction

    // A block side that is not a power of two counts as the next power below.
    function int unsigned blk_log();
      int unsigned lg;
      lg = 0;
      for (int i = 1; i < BlkSideW; i++) begin
        if (blk_side_q[i]) lg = i;
      end
      return lg;
    endfunction

    function int unsigned pow2_ceil(int unsigned v);
      int unsigned p;
      p = 1;
      while (p < v) p = p << 1;
      return p;
    endfunction

    function logic [63:0] run_mask(int unsigned start, int unsigned len);
      logic [63:0] m;
      for (int j = 0; j < 64; j++) m[j] = (j >= start) && (j < start + len);
      return m;
    endfunction

    function status_e try_grant(int unsigned w, int unsigned h, output alloc_result_t res);
      int unsigned big;
      int unsigned run;
      int unsigned lg;
      logic [63:0] m;
      res = '0;
      big = (w > h) ? w : h;
      run = big >> blk_log();
      if (w >= mem_side_q || h >= mem_side_q) return StTooBig;
      if (run == 0) run = 1;
      if (run > BlockCount) return StNoSpace;
      lg = 0;
      while ((1 << lg) < run) lg++;
      for (int unsigned s = 0; s + run <= BlockCount; s += run) begin
        m = run_mask(s, run);
        if ((used_map & m) == '0) begin
          used_map       = used_map | m;
          alloc_start[s] = 1'b1;
          alloc_log[s]   = lg[2:0];
          res.status     = StOk;
          res.slot       = s[SlotW-1:0];
          res.run        = run[RunW-1:0];
          res.width      = w[SizeW-1:0];
          res.height     = h[SizeW-1:0];
          return StOk;
        end
      end
      return StNoSpace;
    endfunction

    function void note_request(action_e act, logic [ReqW-1:0] rw, logic [ReqW-1:0] rh,
                               logic [SlotW-1:0] slot);
      alloc_result_t res;
      int unsigned   w;
      int unsigned   h;
      int unsigned   bs;
      int unsigned   run;
      bit            all_big;
      status_e       st;
      res = '0;
      w  = pow2_ceil((rw == 0) ? 1 : rw);
      h  = pow2_ceil((rh == 0) ? 1 : rh);
      bs = 1 << blk_log();
      case (act)
        ActAllocExact: begin
          st = try_grant(w, h, res);
          res.status = st;
        end
        ActAllocAny: begin
          // Halve both sides after each failed try until one drops below a block.
          all_big = 1'b1;
          st = StNoSpace;
          if (w < bs) w = bs;
          if (h < bs) h = bs;
          while (w >= bs && h >= bs) begin
            st = try_grant(w, h, res);
            if (st == StOk) break;
            if (st != StTooBig) all_big = 1'b0;
            w = w >> 1;
            h = h >> 1;
          end
          if (st != StOk) begin
            res = '0;
            res.status = all_big ? StTooBig : StNoSpace;
          end
        end
        ActFree: begin
          if (!alloc_start[slot]) begin
            res.status = StMissing;
          end else begin
            run = 1 << alloc_log[slot];
            if (slot + run > BlockCount) run = BlockCount - slot;
            used_map = used_map & ~run_mask(slot, run);
            alloc_start[slot] = 1'b0;
            res.status = StOk;
            res.slot   = slot;
            res.run    = run[RunW-1:0];
          end
        end
        default: begin
          used_map = '0;
          foreach (alloc_start[i]) alloc_start[i] = 1'b0;
          res.status = StOk;
        end
      endcase
      expected_q.insert(expected_q.size(), res);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      err_count++;
    endtask

    task check_result(alloc_result_t got);
      alloc_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("result transfer with nothing pending, status %0d", got.status));
      end else begin
        exp = expected_q.pop_front();
        if (got.status != exp.status)
          report($sformatf("status %0d, predicted %0d", got.status, exp.status));
        if (got.slot != exp.slot)
          report($sformatf("slot_index %0d, predicted %0d", got.slot, exp.slot));
        if (got.run != exp.run)
          report($sformatf("run_blocks %0d, predicted %0d", got.run, exp.run));
        if (got.width != exp.width)
          report($sformatf("granted_width %0d, predicted %0d", got.width, exp.width));
        if (got.height != exp.height)
          report($sformatf("granted_height %0d, predicted %0d", got.height, exp.height));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          action_i = ActAllocExact;
  logic [ReqW-1:0]     req_width_i = '0;
  logic [ReqW-1:0]     req_height_i = '0;
  logic [SlotW-1:0]    slot_to_free_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          status_o;
  logic [SlotW-1:0]    slot_index_o;
  logic [RunW-1:0]     run_blocks_o;
  logic [SizeW-1:0]    granted_width_o;
  logic [SizeW-1:0]    granted_height_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  alloc_scoreboard     sb = new();

  aligned_block_bitmap_allocator_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .req_width_i      (req_width_i),
    .req_height_i     (req_height_i),
    .slot_to_free_i   (slot_to_free_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .run_blocks_o     (run_blocks_o),
    .granted_width_o  (granted_width_o),
    .granted_height_o (granted_height_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({status_e'(status_o), slot_index_o, run_blocks_o,
                       granted_width_o, granted_height_o});
    end
  end

  initial begin
    #20_000_000;
    $display("aligned_block_bitmap_allocator_top_tb: errors");
    $finish;
  end

  task automatic send_request(action_e act, logic [ReqW-1:0] w, logic [ReqW-1:0] h,
                              logic [SlotW-1:0] slot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    req_width_i    <= w;
    req_height_i   <= h;
    slot_to_free_i <= slot;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, w, h, slot);
  endtask

  // Lowers valid; waits for every predicted result to be taken, up to DrainLimit.
  task automatic drain_results();
    int unsigned cnt;
    cnt = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0 && cnt < DrainLimit) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_config(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Sides cluster around the block size so that runs of every length show up.
  function automatic logic [ReqW-1:0] pick_side();
    int unsigned e;
    int unsigned v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 16'hFFFF);
      1: v = 0;
      2: v = 16'hFFFF;
      default: begin
        e = $urandom_range(0, sb.blk_log() + 7);
        v = $urandom_range(0, 1 << e);
        if (v > 16'hFFFF) v = 16'hFFFF;
      end
    endcase
    return v[ReqW-1:0];
  endfunction

  task automatic random_request();
    int unsigned       r;
    int unsigned       live[$];
    action_e           act;
    logic [SlotW-1:0]  slot;
    r    = $urandom_range(0, 99);
    slot = SlotW'($urandom_range(0, BlockCount - 1));
    if (r < 45) begin
      act = ActAllocExact;
    end else if (r < 65) begin
      act = ActAllocAny;
    end else if (r < 97) begin
      act = ActFree;
      for (int i = 0; i < BlockCount; i++) begin
        if (sb.alloc_start[i]) live.insert(live.size(), i);
      end
      if (live.size() > 0 && $urandom_range(0, 9) < 8)
        slot = SlotW'(live[$urandom_range(0, live.size() - 1)]);
    end else begin
      act = ActClear;
    end
    send_request(act, pick_side(), pick_side(), slot);
  endtask

  initial begin
    int unsigned cfg_blk[PhaseCount];
    int unsigned cfg_mem[PhaseCount];
    int unsigned n;
    cfg_blk = '{32, 1, 4096, 100, 8, 4096, 1, 16};
    cfg_mem = '{4096, 65536, 2, 1000, 512, 65536, 2, 65535};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part at the reset configuration.
    send_request(ActAllocExact, 16'd0, 16'd0, 6'd0);
    send_request(ActAllocExact, 16'hFFFF, 16'hFFFF, 6'd63);
    send_request(ActAllocAny, 16'hFFFF, 16'hFFFF, 6'd0);
    send_request(ActAllocExact, 16'd2048, 16'd1, 6'd0);
    send_request(ActFree, 16'd0, 16'd0, 6'd0);
    send_request(ActFree, 16'd0, 16'd0, 6'd0);
    send_request(ActFree, 16'hFFFF, 16'hFFFF, 6'd32);
    send_request(ActAllocExact, 16'd33, 16'd17, 6'd0);
    send_request(ActAllocExact, 16'd1, 16'd4095, 6'd0);
    send_request(ActAllocExact, 16'd4097, 16'd1, 6'd0);
    send_request(ActAllocAny, 16'd1, 16'd1, 6'd0);
    send_request(ActAllocAny, 16'd0, 16'd300, 6'd0);
    send_request(ActClear, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_request(ActFree, 16'd0, 16'd0, 6'd63);
    send_request(ActAllocExact, 16'd2048, 16'd2048, 6'd0);
    send_request(ActAllocAny, 16'd5, 16'd5, 6'd0);
    send_request(ActAllocExact, 16'd1, 16'd1, 6'd0);
    send_request(ActFree, 16'd0, 16'd0, 6'd0);
    send_request(ActAllocExact, 16'd64, 16'd64, 6'd0);
    send_request(ActAllocExact, 16'd1024, 16'd512, 6'd0);
    send_request(ActAllocAny, 16'd1500, 16'd1500, 6'd0);
    send_request(ActFree, 16'd0, 16'd0, 6'd32);
    send_request(ActFree, 16'd0, 16'd0, 6'd1);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      apb_write(RegBlockSide, cfg_blk[p]);
      apb_write(RegMemorySide, cfg_mem[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        n = p * PhaseItems + k;
        if (n < 650) begin
          send_idle_pct = 7;
          recv_idle_pct = 49;
        end else if (n < 1300) begin
          send_idle_pct = 49;
          recv_idle_pct = 7;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Hold the sender back once until the block has fully emptied.
        if (k == PhaseItems / 2 && p == 3) drain_results();
        random_request();
      end
    end

    drain_results();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.expected_q.size()));
    if (sb.err_count == 0) begin
      $display("aligned_block_bitmap_allocator_top_tb: clean");
    end else begin
      $display("aligned_block_bitmap_allocator_top_tb: errors");
    end
    $finish;
  end

endmodule
